@@ sv/wwmmr_pkg.sv @@
// shared constants for the windowed min/max/rms block
package wwmmr_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int WINDOW_BITS_DEF = 16;

endpackage

@@ sv/waveform_window_min_max_rms_core.sv @@
// Windowed min / max / RMS summary of a stream of signed Q1.15 samples.
// Samples are grouped into windows of window_length samples (a length of 0 acts as 1), and
// each closed window gives one result with its smallest sample, its largest sample and
// floor(sqrt(floor(sum of squares / count))). A sample with last_sample set closes a partial
// window at once and its RMS uses the true count. Each sample is taken in a transfer step and
// then squared and accumulated, with min/max updated, in the accumulate step; a closing sample
// goes on to the divide and square-root steps and then loads the output register. The
// accumulator is min(2*SAMPLE_BITS + WINDOW_BITS - 2, 64) bits wide.
// A restoring divider retires one quotient bit a cycle, then a digit-by-digit square root
// retires one root bit a cycle, both on a single shared subtract/compare unit. A finished
// result sits in the output register while the next samples are taken; the block waits
// only when a new result is ready and the previous one has not been transferred.
module waveform_window_min_max_rms_core #(
	parameter int SAMPLE_BITS = wwmmr_pkg::SAMPLE_BITS_DEF,
	parameter int WINDOW_BITS = wwmmr_pkg::WINDOW_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [WINDOW_BITS-1:0]        cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] window_min,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	output logic [SAMPLE_BITS-1:0]        window_rms,
	output logic                          final_window
);

	localparam int ACC_FULL    = 2 * SAMPLE_BITS + WINDOW_BITS - 2;
	localparam int ACC_BITS    = (ACC_FULL > 64) ? 64 : ACC_FULL;
	localparam int SUB_BITS    = (ACC_BITS > WINDOW_BITS + 2) ? ACC_BITS : WINDOW_BITS + 2;
	localparam int SQRT_STEPS  = (ACC_BITS - 1) / 2 + 1;
	localparam int STEP_BITS   = $clog2(ACC_BITS + 1);
	localparam int BIT_POS     = 2 * ((ACC_BITS - 1) / 2);
	localparam logic [ACC_BITS-1:0] BIT_INIT = ACC_BITS'(1) << BIT_POS;
	localparam logic [SAMPLE_BITS-1:0] RMS_MAX = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [WINDOW_BITS-1:0]          len_q;
	logic signed [SAMPLE_BITS-1:0]   sample_q;
	logic                            last_q;
	logic signed [SAMPLE_BITS-1:0]   min_q;
	logic signed [SAMPLE_BITS-1:0]   max_q;
	logic [ACC_BITS-1:0]             sum_q;
	logic [WINDOW_BITS-1:0]          cnt_q;
	logic                            final_q;
	logic [ACC_BITS-1:0]             dvd_q;
	logic [WINDOW_BITS:0]            rem_q;
	logic [WINDOW_BITS:0]            dvs_q;
	logic [ACC_BITS-1:0]             res_q;
	logic [ACC_BITS-1:0]             bit_q;
	logic [STEP_BITS-1:0]            step_q;
	logic                            out_valid_q;
	logic signed [SAMPLE_BITS-1:0]   out_min_q;
	logic signed [SAMPLE_BITS-1:0]   out_max_q;
	logic [SAMPLE_BITS-1:0]          out_rms_q;
	logic                            out_final_q;

	logic signed [2*SAMPLE_BITS-1:0] sample_ext;
	logic signed [2*SAMPLE_BITS-1:0] sq_full;
	logic [ACC_BITS-1:0]             sq_ext;
	logic [ACC_BITS:0]               sum_add;
	logic [ACC_BITS-1:0]             sum_next;
	logic [WINDOW_BITS-1:0]          cnt_next;
	logic [WINDOW_BITS-1:0]          len_eff;
	logic                            close;
	logic [WINDOW_BITS+1:0]          rem2;
	logic [SUB_BITS-1:0]             sub_a;
	logic [SUB_BITS-1:0]             sub_b;
	logic [SUB_BITS:0]               sub_diff;
	logic                            sub_ge;
	logic                            out_free;

	// accumulate stage
	assign sample_ext = {{SAMPLE_BITS{sample_q[SAMPLE_BITS-1]}}, sample_q};
	assign sq_full    = sample_ext * sample_ext;
	assign sq_ext     = ACC_BITS'($unsigned(sq_full));
	assign sum_add    = {1'b0, sum_q} + {1'b0, sq_ext};
	// saturate on carry out of the accumulator
	assign sum_next   = (cnt_q == '0) ? sq_ext :
	                    (sum_add[ACC_BITS] ? '1 : sum_add[ACC_BITS-1:0]);
	assign cnt_next   = cnt_q + WINDOW_BITS'(1);
	assign len_eff    = (len_q == '0) ? WINDOW_BITS'(1) : len_q;
	assign close      = (cnt_next >= len_eff) || (cnt_next == '0) || last_q;

	// shared subtract/compare unit for divide and square root
	assign rem2     = {rem_q, dvd_q[ACC_BITS-1]};
	assign sub_a    = (state_q == ST_DIV) ? SUB_BITS'(rem2) : SUB_BITS'(dvd_q);
	assign sub_b    = (state_q == ST_DIV) ? SUB_BITS'(dvs_q) : SUB_BITS'(res_q | bit_q);
	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge   = !sub_diff[SUB_BITS];

	assign out_free = !out_valid_q || !out_stall;

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign window_min   = out_min_q;
	assign window_max   = out_max_q;
	assign window_rms   = out_rms_q;
	assign final_window = out_final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= WINDOW_BITS'(1);
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				len_q <= cfg_wr_data;
			end
			// the done state reloads the output register itself
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sample_q <= sample;
						last_q   <= last_sample;
						state_q  <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (cnt_q == '0 || sample_q < min_q) begin
						min_q <= sample_q;
					end
					if (cnt_q == '0 || sample_q > max_q) begin
						max_q <= sample_q;
					end
					if (close) begin
						cnt_q   <= '0;
						final_q <= last_q;
						dvd_q   <= sum_next;
						rem_q   <= '0;
						// a wrapped count means a full 2^WINDOW_BITS window
						dvs_q   <= (cnt_next == '0) ? {1'b1, {WINDOW_BITS{1'b0}}} :
						           {1'b0, cnt_next};
						step_q  <= STEP_BITS'(ACC_BITS - 1);
						state_q <= ST_DIV;
					end else begin
						sum_q   <= sum_next;
						cnt_q   <= cnt_next;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					rem_q <= sub_ge ? sub_diff[WINDOW_BITS:0] : rem2[WINDOW_BITS:0];
					dvd_q <= {dvd_q[ACC_BITS-2:0], sub_ge};
					if (step_q == '0) begin
						res_q   <= '0;
						bit_q   <= BIT_INIT;
						step_q  <= STEP_BITS'(SQRT_STEPS - 1);
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q - STEP_BITS'(1);
					end
				end
				ST_SQRT: begin
					if (sub_ge) begin
						dvd_q <= sub_diff[ACC_BITS-1:0];
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - STEP_BITS'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_min_q   <= min_q;
						out_max_q   <= max_q;
						out_rms_q   <= res_q[SAMPLE_BITS-1:0];
						out_final_q <= final_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_transfer_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_ACC))
		else $error("accepted sample not accumulated");

	a_rms_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_rms_q <= RMS_MAX))
		else $error("rms above full scale");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q && $stable(out_rms_q))
		else $error("pending result overwritten");
`endif

endmodule
